// ----- hw/rtl/flut_pkg.sv -----
// Shared constants for the frame load utilization tracker.
// Holds the register indexes, field codes and reset values of the derived terms.
// Depends on nothing; the top level refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package flut_pkg;

  localparam int FT_W       = 30;  // frame time in ns, always below 2^30
  localparam int UTIL_W     = 11;
  localparam int VL_W       = 32;
  localparam int MS_W       = 12;  // signed ramp length in ms
  localparam int MSQ_W      = 10;  // frame time in whole ms, at most 1000
  localparam int UTIL_SHIFT = 10;  // loads are scaled by 1024
  localparam int INV_SHIFT  = 2;   // exec time is compared against timeline / 4
  localparam int OUT_DATA_W = 48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [UTIL_W-1:0] UTIL_FULL = 11'd1024;
  localparam logic [FT_W-1:0]   NS_PER_S  = 30'd1000000000;
  localparam logic [FT_W-1:0]   NS_PER_MS = 30'd1000000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VLOAD_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UTIL     = 2'd2;

  localparam logic [6:0]        RATE_RESET   = 7'd60;
  localparam logic [6:0]        RATE_MIN     = 7'd1;
  localparam logic [6:0]        RATE_MAX     = 7'd120;
  localparam logic signed [7:0] MARGIN_RESET = 8'sd16;
  localparam logic signed [7:0] MARGIN_MIN   = -8'sd100;
  localparam logic signed [7:0] MARGIN_MAX   = 8'sd100;
  localparam logic [UTIL_W-1:0] MAX_UTIL_RESET = 11'd1024;

  // Derived terms for the reset configuration (60 fps, 16 ms margin).
  localparam logic [FT_W-1:0]        FT_RESET = 30'd16666666;
  localparam logic signed [MS_W-1:0] MS_RESET = 12'sd32;
  localparam logic [UTIL_W-1:0]      K_RESET  = 11'd32;

  // Opcodes and frame event codes.
  localparam logic       OP_TIMESTAMP = 1'b0;
  localparam logic       OP_TICK      = 1'b1;
  localparam logic [1:0] EV_START     = 2'd0;
  localparam logic [1:0] EV_END       = 2'd1;

  // Frame state codes as reported.
  localparam logic [1:0] FS_START = 2'd0;
  localparam logic [1:0] FS_END   = 2'd1;

  // Update kinds.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_NORMAL = 2'd1;
  localparam logic [1:0] KIND_FORCED = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/frame_load_util_tracker_top.sv -----
// Frame-paced utilization tracker: one result word per input word.
// Uses flut_pkg for codes and constants; holds a bit-serial restoring divider.
//
//  channel | ports                         | word contents (lowest bit first)
//  --------+-------------------------------+-----------------------------------------
//  input   | in_tvalid/in_tready           | tdata: frame_event, skip_start, skip_end,
//          | in_tdata, in_tuser            |   use_margin_now, timeline, window_load,
//          |                               |   window_exec, closed_window_load,
//          |                               |   invalid_interval; tuser: opcode
//  result  | out_tvalid/out_tready         | tdata: util, vload, rollover, error,
//          | out_tdata, out_tuser          |   frame_state; tuser: update_kind
//  config  | cfg_wen/cfg_index/cfg_wdata   | one register per write, no read-back
//
// A word that needs a load division (frame end, frame start, tick with window scaling) steps
// the divider through every bit of its scaled load, a ramp tick through the timeline bits only,
// and other words skip it; the divider retires one quotient bit per cycle.
// A configuration write starts a recompute of frame time, ramp length and, for a positive ramp
// length, 1024 / ramp length on the same divider, during which no word is accepted.
// Reset is synchronous and leaves the derived terms for the reset configuration.
// A finished result waits in the output register; the next word is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module frame_load_util_tracker_top #(
  parameter int TIME_BITS = 40
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // frame_event[1:0], skip_start, skip_end, use_margin_now, timeline_ns,
  // window_load_ns, window_exec_ns, closed_window_load_ns, invalid_interval_ns
  input  logic [((5 + 5 * TIME_BITS + 7) / 8) * 8 - 1:0]  in_tdata,
  // opcode
  input  logic                                            in_tuser,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // util[10:0], vload[31:0], rollover, error, frame_state[1:0], zero pad
  output logic [flut_pkg::OUT_DATA_W-1:0]                 out_tdata,
  // update_kind
  output logic [1:0]                                      out_tuser,
  input  logic                                            cfg_wen,
  input  logic [flut_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [flut_pkg::CFG_DATA_W-1:0]                 cfg_wdata
);

  localparam int FT_W   = flut_pkg::FT_W;
  localparam int UTIL_W = flut_pkg::UTIL_W;
  localparam int VL_W   = flut_pkg::VL_W;
  localparam int MS_W   = flut_pkg::MS_W;
  localparam int MSQ_W  = flut_pkg::MSQ_W;
  localparam int USH    = flut_pkg::UTIL_SHIFT;
  localparam int DVD_W  = TIME_BITS + USH;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CFG_START,
    S_CFG_FT,
    S_CFG_MS,
    S_CFG_K,
    S_DECODE,
    S_DIV,
    S_PREP,
    S_MUL,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_LTU,
    JOB_SCALED,
    JOB_RAMP
  } job_t;

  typedef enum logic [2:0] {
    VL_ZERO,
    VL_FULL,
    VL_MUL,
    VL_QUO,
    VL_SAT
  } vl_sel_t;

  state_t state_r;

  // Configuration and derived terms.
  logic [6:0]               rate_r;
  logic signed [7:0]        margin_r;
  logic [UTIL_W-1:0]        max_util_r;
  logic [FT_W-1:0]          ft_r;
  logic signed [MS_W-1:0]   ms_len_r;
  logic [UTIL_W-1:0]        k_r;
  logic                     cfg_dirty_r;

  // Tracker state.
  logic [1:0]               fs_r;
  logic                     skipping_r;
  logic [UTIL_W-1:0]        prev_real_r;
  logic [UTIL_W-1:0]        prev_fake_r;

  // Captured word.
  logic                     op_r;
  logic [1:0]               ev_r;
  logic                     ss_r;
  logic                     se_r;
  logic                     umn_r;
  logic [TIME_BITS-1:0]     t_r;
  logic [TIME_BITS-1:0]     wload_r;
  logic [TIME_BITS-1:0]     wexec_r;
  logic [TIME_BITS-1:0]     closed_r;
  logic [TIME_BITS-1:0]     inval_r;

  // Per-word decisions and intermediate results.
  job_t                     job_r;
  logic                     go_r;
  logic                     cl_full_r;
  vl_sel_t                  vl_sel_r;
  logic [UTIL_W-1:0]        u_r;
  logic [UTIL_W-1:0]        mul_a_r;
  logic [UTIL_W-1:0]        mul_b_r;
  logic [VL_W-1:0]          vl_r;

  // Divider.
  logic [DVD_W-1:0]         dvd_r;
  logic [FT_W-1:0]          dvs_r;
  logic [FT_W-1:0]          rem_r;
  logic [VL_W-1:0]          quo_r;
  logic                     ovf_r;
  logic [CNT_W-1:0]         cnt_r;

  // Result register.
  logic                     out_valid_r;
  logic [UTIL_W-1:0]        out_util_r;
  logic [VL_W-1:0]          out_vload_r;
  logic [1:0]               out_kind_r;
  logic                     out_roll_r;
  logic                     out_err_r;
  logic [1:0]               out_fs_r;

  // ---------------------------------------------------------------------------
  // Divider step: one restoring step per cycle, quotient bits shifted in at the bottom.
  // Quotient bits that fall off the top are kept as a sticky overflow.
  logic [FT_W:0]      rem_sh;
  logic [FT_W:0]      rem_dif;
  logic               q_bit;
  logic [FT_W-1:0]    rem_step;
  logic [VL_W-1:0]    quo_step;
  logic               ovf_step;
  logic [DVD_W-1:0]   dvd_step;
  logic               div_active;
  logic               div_last;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_dif  = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_step = q_bit ? rem_dif[FT_W-1:0] : rem_sh[FT_W-1:0];
  assign quo_step = {quo_r[VL_W-2:0], q_bit};
  assign ovf_step = ovf_r | quo_r[VL_W-1];
  assign dvd_step = {dvd_r[DVD_W-2:0], 1'b0};
  assign div_last = (cnt_r == CNT_W'(1));
  assign div_active = (state_r == S_DIV) || (state_r == S_CFG_FT) ||
                      (state_r == S_CFG_MS) || (state_r == S_CFG_K);

  // Ramp length from the whole-millisecond frame time just divided out.
  logic signed [MS_W-1:0] ms_len_new;
  logic                   ms_new_pos;
  logic                   ms_pos;

  assign ms_len_new = {{(MS_W-MSQ_W){1'b0}}, quo_step[MSQ_W-1:0]} +
                      {{(MS_W-8){margin_r[7]}}, margin_r};
  assign ms_new_pos = !ms_len_new[MS_W-1] && (ms_len_new != '0);
  assign ms_pos     = !ms_len_r[MS_W-1] && (ms_len_r != '0);

  // ---------------------------------------------------------------------------
  // Decode of the captured word.
  logic [TIME_BITS-1:0] ft_ext;
  logic                 t_ge_ft;
  logic                 cl_ge_ft;
  logic                 bad;
  logic                 go;
  job_t                 job_sel;

  assign ft_ext   = {{(TIME_BITS-FT_W){1'b0}}, ft_r};
  assign t_ge_ft  = (t_r >= ft_ext);
  assign cl_ge_ft = (closed_r >= ft_ext);
  assign bad      = (inval_r <= t_r) && (wexec_r <= (t_r >> flut_pkg::INV_SHIFT));
  assign go       = ss_r | se_r | !skipping_r;

  always_comb begin
    job_sel = JOB_NONE;
    if (op_r == flut_pkg::OP_TIMESTAMP) begin
      if (go && ((ev_r == flut_pkg::EV_START) ||
                 ((ev_r == flut_pkg::EV_END) && (fs_r != flut_pkg::FS_END)))) begin
        job_sel = JOB_LTU;
      end
    end else if (fs_r == flut_pkg::FS_START) begin
      job_sel = bad ? JOB_LTU : JOB_RAMP;
    end else begin
      job_sel = t_ge_ft ? JOB_LTU : JOB_SCALED;
    end
  end

  // ---------------------------------------------------------------------------
  // Ramp terms from the millisecond quotient. Only used while the ramp length is positive,
  // so it fits eleven unsigned bits.
  logic [UTIL_W-1:0] v11;
  logic              v_gt_m;
  logic [UTIL_W:0]   f_sum;
  logic [UTIL_W:0]   f_dif;
  logic              f_le_m;

  assign v11    = quo_r[UTIL_W-1:0];
  assign v_gt_m = ovf_r || (|quo_r[VL_W-1:UTIL_W]) || (v11 > ms_len_r[UTIL_W-1:0]);
  assign f_sum  = {1'b0, v11} + {1'b0, k_r};
  assign f_le_m = (f_sum <= $unsigned(ms_len_r));
  assign f_dif  = f_sum - $unsigned(ms_len_r);

  logic [2*UTIL_W-1:0] prod;
  assign prod = mul_a_r * mul_b_r;

  // ---------------------------------------------------------------------------
  // Result and state update for the finishing word.
  logic [1:0]        fin_fs;
  logic              fin_skip;
  logic [UTIL_W-1:0] fin_prev_real;
  logic [UTIL_W-1:0] fin_prev_fake;
  logic [UTIL_W-1:0] base;
  logic [1:0]        fin_kind;
  logic              fin_roll;
  logic              fin_err;
  logic [VL_W-1:0]   base_ext;
  logic [VL_W-1:0]   hi;
  logic [UTIL_W-1:0] fin_util;
  logic              out_free;

  always_comb begin
    fin_fs        = fs_r;
    fin_skip      = skipping_r;
    fin_prev_real = prev_real_r;
    fin_prev_fake = prev_fake_r;
    base          = '0;
    fin_kind      = flut_pkg::KIND_NONE;
    fin_roll      = 1'b0;
    fin_err       = 1'b0;
    if (op_r == flut_pkg::OP_TIMESTAMP) begin
      if (ss_r) begin
        fin_skip = 1'b1;
      end else if (se_r) begin
        fin_skip = 1'b0;
      end
      if (go_r) begin
        if (ev_r == flut_pkg::EV_START) begin
          // A start while already started closes a real frame; otherwise a fake one.
          if (fs_r == flut_pkg::FS_START) begin
            fin_prev_real = u_r;
            base          = u_r;
          end else begin
            fin_prev_fake = u_r;
            base          = prev_real_r;
          end
          fin_fs   = flut_pkg::FS_START;
          fin_kind = flut_pkg::KIND_FORCED;
        end else if (ev_r == flut_pkg::EV_END) begin
          if (fs_r != flut_pkg::FS_END) begin
            fin_prev_real = u_r;
            base          = u_r;
            fin_fs        = flut_pkg::FS_END;
            fin_kind      = flut_pkg::KIND_FORCED;
          end
        end else begin
          fin_err = 1'b1;
        end
      end
    end else begin
      fin_kind = flut_pkg::KIND_NORMAL;
      if (job_r == JOB_LTU) begin
        // The tick closes the frame itself: invalidated while started, or timed out.
        fin_roll = 1'b1;
        fin_fs   = flut_pkg::FS_END;
        base     = u_r;
        if (fs_r == flut_pkg::FS_START) begin
          fin_prev_real = u_r;
        end else begin
          fin_prev_fake = u_r;
        end
      end else begin
        base = (fs_r == flut_pkg::FS_START) ? prev_real_r : prev_fake_r;
      end
    end
  end

  assign base_ext = {{(VL_W-UTIL_W){1'b0}}, base};
  assign hi       = (vl_r > base_ext) ? vl_r : base_ext;
  assign fin_util = (hi > {{(VL_W-UTIL_W){1'b0}}, max_util_r}) ? max_util_r : hi[UTIL_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------------
  // Configuration write decode.
  logic [6:0]        wr_rate;
  logic signed [7:0] wr_margin;
  logic [UTIL_W-1:0] wr_max;

  assign wr_rate   = cfg_wdata[6:0];
  assign wr_margin = $signed(cfg_wdata[7:0]);
  assign wr_max    = cfg_wdata[UTIL_W-1:0];

  assign in_tready = (state_r == S_IDLE) && !cfg_dirty_r && !cfg_wen;

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= flut_pkg::RATE_RESET;
      margin_r    <= flut_pkg::MARGIN_RESET;
      max_util_r  <= flut_pkg::MAX_UTIL_RESET;
      ft_r        <= flut_pkg::FT_RESET;
      ms_len_r    <= flut_pkg::MS_RESET;
      k_r         <= flut_pkg::K_RESET;
      cfg_dirty_r <= 1'b0;
      fs_r        <= flut_pkg::FS_END;
      skipping_r  <= 1'b0;
      prev_real_r <= '0;
      prev_fake_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          flut_pkg::REG_FRAME_RATE: begin
            if (wr_rate >= flut_pkg::RATE_MIN && wr_rate <= flut_pkg::RATE_MAX) begin
              rate_r <= wr_rate;
            end
          end
          flut_pkg::REG_VLOAD_MARGIN: begin
            if (wr_margin >= flut_pkg::MARGIN_MIN && wr_margin <= flut_pkg::MARGIN_MAX) begin
              margin_r <= wr_margin;
            end
          end
          flut_pkg::REG_MAX_UTIL: begin
            if (wr_max <= flut_pkg::UTIL_FULL) begin
              max_util_r <= wr_max;
            end
          end
          default: begin
          end
        endcase
      end

      // A write during a recompute marks it stale again, so it reruns from idle.
      if (cfg_wen) begin
        cfg_dirty_r <= 1'b1;
      end else if (state_r == S_IDLE) begin
        cfg_dirty_r <= 1'b0;
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (div_active) begin
        dvd_r <= dvd_step;
        rem_r <= rem_step;
        quo_r <= quo_step;
        ovf_r <= ovf_step;
        cnt_r <= cnt_r - CNT_W'(1);
      end

      case (state_r)
        S_IDLE: begin
          if (cfg_dirty_r) begin
            state_r <= S_CFG_START;
          end else if (in_tvalid && in_tready) begin
            op_r     <= in_tuser;
            ev_r     <= in_tdata[1:0];
            ss_r     <= in_tdata[2];
            se_r     <= in_tdata[3];
            umn_r    <= in_tdata[4];
            t_r      <= in_tdata[5 +: TIME_BITS];
            wload_r  <= in_tdata[5 + TIME_BITS +: TIME_BITS];
            wexec_r  <= in_tdata[5 + 2 * TIME_BITS +: TIME_BITS];
            closed_r <= in_tdata[5 + 3 * TIME_BITS +: TIME_BITS];
            inval_r  <= in_tdata[5 + 4 * TIME_BITS +: TIME_BITS];
            state_r  <= S_DECODE;
          end
        end

        S_CFG_START: begin
          dvd_r   <= {flut_pkg::NS_PER_S, {(DVD_W-FT_W){1'b0}}};
          dvs_r   <= {{(FT_W-7){1'b0}}, rate_r};
          rem_r   <= '0;
          quo_r   <= '0;
          ovf_r   <= 1'b0;
          cnt_r   <= CNT_W'(FT_W);
          state_r <= S_CFG_FT;
        end

        S_CFG_FT: begin
          if (div_last) begin
            ft_r    <= quo_step[FT_W-1:0];
            dvd_r   <= {quo_step[FT_W-1:0], {(DVD_W-FT_W){1'b0}}};
            dvs_r   <= flut_pkg::NS_PER_MS;
            rem_r   <= '0;
            quo_r   <= '0;
            ovf_r   <= 1'b0;
            cnt_r   <= CNT_W'(FT_W);
            state_r <= S_CFG_MS;
          end
        end

        S_CFG_MS: begin
          if (div_last) begin
            ms_len_r <= ms_len_new;
            if (ms_new_pos) begin
              dvd_r   <= {flut_pkg::UTIL_FULL, {(DVD_W-UTIL_W){1'b0}}};
              dvs_r   <= {{(FT_W-UTIL_W){1'b0}}, ms_len_new[UTIL_W-1:0]};
              rem_r   <= '0;
              quo_r   <= '0;
              ovf_r   <= 1'b0;
              cnt_r   <= CNT_W'(UTIL_W);
              state_r <= S_CFG_K;
            end else begin
              k_r     <= '0;
              state_r <= S_IDLE;
            end
          end
        end

        S_CFG_K: begin
          if (div_last) begin
            k_r     <= quo_step[UTIL_W-1:0];
            state_r <= S_IDLE;
          end
        end

        S_DECODE: begin
          job_r     <= job_sel;
          go_r      <= go;
          cl_full_r <= cl_ge_ft;
          rem_r     <= '0;
          quo_r     <= '0;
          ovf_r     <= 1'b0;
          case (job_sel)
            JOB_LTU: begin
              // A closed load of a whole frame or more is full scale without dividing.
              if (cl_ge_ft) begin
                state_r <= S_PREP;
              end else begin
                dvd_r   <= {closed_r, {USH{1'b0}}};
                dvs_r   <= ft_r;
                cnt_r   <= CNT_W'(DVD_W);
                state_r <= S_DIV;
              end
            end
            JOB_SCALED: begin
              dvd_r   <= {wload_r, {USH{1'b0}}};
              dvs_r   <= ft_r;
              cnt_r   <= CNT_W'(DVD_W);
              state_r <= S_DIV;
            end
            JOB_RAMP: begin
              if (ms_pos) begin
                dvd_r   <= {t_r, {USH{1'b0}}};
                dvs_r   <= flut_pkg::NS_PER_MS;
                cnt_r   <= CNT_W'(TIME_BITS);
                state_r <= S_DIV;
              end else begin
                state_r <= S_PREP;
              end
            end
            default: begin
              state_r <= S_PREP;
            end
          endcase
        end

        S_DIV: begin
          if (div_last) begin
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          u_r     <= cl_full_r ? flut_pkg::UTIL_FULL : {1'b0, quo_r[USH-1:0]};
          mul_a_r <= v11;
          mul_b_r <= f_dif[UTIL_W-1:0];
          case (job_r)
            JOB_RAMP: begin
              if (!ms_pos || v_gt_m) begin
                vl_sel_r <= VL_FULL;
              end else if ((v11 == '0) || f_le_m) begin
                vl_sel_r <= VL_ZERO;
              end else begin
                vl_sel_r <= VL_MUL;
              end
            end
            JOB_SCALED: begin
              vl_sel_r <= ovf_r ? VL_SAT : VL_QUO;
            end
            JOB_LTU: begin
              // The ramp at time zero is full scale only for a non-positive ramp length.
              if ((op_r == flut_pkg::OP_TIMESTAMP) && (ev_r == flut_pkg::EV_START) &&
                  umn_r && !ms_pos) begin
                vl_sel_r <= VL_FULL;
              end else begin
                vl_sel_r <= VL_ZERO;
              end
            end
            default: begin
              vl_sel_r <= VL_ZERO;
            end
          endcase
          state_r <= S_MUL;
        end

        S_MUL: begin
          case (vl_sel_r)
            VL_FULL: vl_r <= {{(VL_W-UTIL_W){1'b0}}, flut_pkg::UTIL_FULL};
            VL_MUL:  vl_r <= {{(VL_W-2*UTIL_W){1'b0}}, prod};
            VL_QUO:  vl_r <= quo_r;
            VL_SAT:  vl_r <= '1;
            default: vl_r <= '0;
          endcase
          state_r <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            fs_r        <= fin_fs;
            skipping_r  <= fin_skip;
            prev_real_r <= fin_prev_real;
            prev_fake_r <= fin_prev_fake;
            out_util_r  <= fin_util;
            out_vload_r <= vl_r;
            out_kind_r  <= fin_kind;
            out_roll_r  <= fin_roll;
            out_err_r   <= fin_err;
            out_fs_r    <= fin_fs;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_fs_r, out_err_r, out_roll_r, out_vload_r, out_util_r};
  assign out_tuser  = out_kind_r;

`ifndef ASSERT_OFF
  // A finishing word with room in the output register always presents a result.
  a_finish_presents: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> out_valid_r)
    else $error("finished word did not reach the output register");

  // The divider never runs with an exhausted step count.
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    div_active |-> (cnt_r != '0))
    else $error("divider stepping with zero count");

  // A rollover only comes from a tick and always leaves the frame ended.
  a_roll_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_roll_r) |->
      (out_fs_r == flut_pkg::FS_END && out_kind_r == flut_pkg::KIND_NORMAL))
    else $error("rollover result without a closed frame");

  // An invalid timestamp event requests nothing.
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      (out_util_r == '0 && out_vload_r == '0 && out_kind_r == flut_pkg::KIND_NONE))
    else $error("invalid event produced a request");
`endif

endmodule

`default_nettype wire
